// File: hw/rtl/ring_symmetry_class_enumerator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ring symmetry class enumerator
// Shared property shorthands; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef RING_SYMMETRY_CLASS_ENUMERATOR_UNIT_MACROS_SVH
`define RING_SYMMETRY_CLASS_ENUMERATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define RSCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RSCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rsce_pkg.sv
// ----------------------------------------------------------------------------
// rsce_pkg
// Types, codes and default sizes of the ring symmetry class enumerator.
// ----------------------------------------------------------------------------
`default_nettype none
package rsce_pkg;

  // Default sizes
  localparam int unsigned STATE_BITS_DEF     = 16;
  localparam int unsigned MASK_WORD_BITS_DEF = 32;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned MADDR_W = 11;
  localparam int unsigned MWORD_W = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned REP_W   = 16;
  localparam int unsigned RC_W    = 4;
  localparam int unsigned CI_W    = 16;
  localparam int unsigned SITES_W = 5;
  localparam int unsigned SYMB_W  = 3;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned CNT_W   = 17;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SITES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS = 1'd1;

  // Operations; the last code is accepted and ignored
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_ROT_BAD  = 3'd1;
  localparam logic [STAT_W-1:0] ST_REF_BAD  = 3'd2;
  localparam logic [STAT_W-1:0] ST_MROT_BAD = 3'd3;
  localparam logic [STAT_W-1:0] ST_SIZE     = 3'd4;

  // Functions of the shared permutation unit
  typedef enum logic {
    PF_ROT,
    PF_STEP
  } perm_fn_t;

endpackage
`default_nettype wire

// File: hw/rtl/rsce_in_if.sv
// ----------------------------------------------------------------------------
// rsce_in_if
// Input channel: operation, mask address and mask word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface rsce_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsce_pkg::OP_W-1:0]    operation;
  logic [rsce_pkg::MADDR_W-1:0] mask_address;
  logic [rsce_pkg::MWORD_W-1:0] mask_word;

  modport source (output valid, output operation, output mask_address,
                  output mask_word, input ready);
  modport sink   (input valid, input operation, input mask_address,
                  input mask_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rsce_out_if.sv
// ----------------------------------------------------------------------------
// rsce_out_if
// Result channel: class record with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface rsce_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsce_pkg::STAT_W-1:0] status;
  logic [rsce_pkg::REP_W-1:0]  representative;
  logic [rsce_pkg::RC_W-1:0]   rotation_count;
  logic                       mirror_merged;
  logic [rsce_pkg::CI_W-1:0]   class_index;

  modport source (output valid, output status, output representative,
                  output rotation_count, output mirror_merged,
                  output class_index, input ready);
  modport sink   (input valid, input status, input representative,
                  input rotation_count, input mirror_merged,
                  input class_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rsce_ram.sv
// ----------------------------------------------------------------------------
// rsce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rsce_ram #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 2,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsce_perm_unit.sv
// ----------------------------------------------------------------------------
// rsce_perm_unit
// Shared symbol shifter: one-symbol ring rotation or one reflection step.
// ----------------------------------------------------------------------------
`default_nettype none
module rsce_perm_unit #(
  parameter int unsigned STATE_BITS = rsce_pkg::STATE_BITS_DEF
) (
  input  wire rsce_pkg::perm_fn_t            fn,
  input  wire logic [STATE_BITS-1:0]        a,
  input  wire logic [STATE_BITS-1:0]        b,
  input  wire logic [rsce_pkg::LEN_W-1:0]   len,
  input  wire logic [rsce_pkg::SYMB_W-1:0]  sb,
  output logic      [STATE_BITS-1:0]        y,
  output logic      [STATE_BITS-1:0]        z
);
  import rsce_pkg::*;

  logic [STATE_BITS:0]   len_one;
  logic [STATE_BITS-1:0] len_mask;
  logic [STATE_BITS-1:0] sym_mask;
  logic [LEN_W-1:0]      back_sh;

  assign len_one  = (STATE_BITS+1)'(1) << len;
  assign len_mask = len_one[STATE_BITS-1:0] - STATE_BITS'(1);
  assign sym_mask = ~({STATE_BITS{1'b1}} << sb);
  assign back_sh  = len - LEN_W'(sb);

  // Rotate by one symbol, or move the low symbol of a onto the accumulator b
  always_comb begin
    case (fn)
      PF_ROT: begin
        y = ((a << sb) | (a >> back_sh)) & len_mask;
        z = '0;
      end
      PF_STEP: begin
        y = (b << sb) | (a & sym_mask);
        z = a >> sb;
      end
      default: begin
        y = '0;
        z = '0;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/ring_symmetry_class_enumerator_unit.sv
// Scans ring configurations in ascending order, one per process item, and
// reports each new bracelet class (rotation plus reflection) with its
// representative, rotation count, mirror flag and running index. A mask
// word load leaves the unit idle, so loads can follow back to back. A
// process item reads the configuration, walks its rotation images, builds
// the reflection symbol by symbol, then checks the mirror image and its
// further rotations, and may then wait on the result channel; an invalid
// configuration is dropped after its mask check and a size error goes
// straight to the result channel. Each image costs one registered read of
// the validity-mask and visited-map RAMs. After reset and after every
// restart item the visited map is cleared one entry a cycle, during which no
// item is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// ring_symmetry_class_enumerator_unit
// Top level: sequencer, configuration registers, mask and visited RAMs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ring_symmetry_class_enumerator_unit_macros.svh"
module ring_symmetry_class_enumerator_unit #(
  parameter int unsigned STATE_BITS     = rsce_pkg::STATE_BITS_DEF,
  parameter int unsigned MASK_WORD_BITS = rsce_pkg::MASK_WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rsce_in_if.sink                             in_ch,
  rsce_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rsce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsce_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rsce_pkg::*;

  localparam int unsigned CONF_COUNT = 2 ** STATE_BITS;
  localparam int unsigned MASK_DEPTH = (CONF_COUNT + MASK_WORD_BITS - 1) / MASK_WORD_BITS;
  localparam int unsigned MA_W       = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam int unsigned BI_W       = $clog2(MASK_WORD_BITS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_N_RD, S_N_CK, S_ROT_RD, S_ROT_CK, S_REF,
    S_REFL_RD, S_REFL_CK, S_MROT_RD, S_MROT_CK, S_FIN, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [SITES_W-1:0]    rs_r, rs_nxt;
  logic [SYMB_W-1:0]     sb_r, sb_nxt;
  logic [STATE_BITS:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  halted_r, halted_nxt;
  logic [STATE_BITS-1:0] n_r, n_nxt;
  logic [STATE_BITS-1:0] cand_r, cand_nxt;
  logic [STATE_BITS-1:0] ref_r, ref_nxt;
  logic [STATE_BITS-1:0] sh_r, sh_nxt;
  logic [STATE_BITS-1:0] acc_r, acc_nxt;
  logic [SITES_W-1:0]    k_r, k_nxt;
  logic [RC_W-1:0]       rc_r, rc_nxt;
  logic                  mm_r, mm_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [STATE_BITS-1:0] clr_r, clr_nxt;
  logic [STAT_W-1:0]     res_st_r, res_st_nxt;
  logic [REP_W-1:0]      res_rep_r, res_rep_nxt;
  logic [RC_W-1:0]       res_rc_r, res_rc_nxt;
  logic                  res_mm_r, res_mm_nxt;
  logic [CI_W-1:0]       res_ci_r, res_ci_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_st_r, out_st_nxt;
  logic [REP_W-1:0]      out_rep_r, out_rep_nxt;
  logic [RC_W-1:0]       out_rc_r, out_rc_nxt;
  logic                  out_mm_r, out_mm_nxt;
  logic [CI_W-1:0]       out_ci_r, out_ci_nxt;

  logic [LEN_W-1:0]          len;
  logic                      size_bad;
  logic [STATE_BITS:0]       scan_lim;
  logic                      mask_we;
  logic [MASK_WORD_BITS-1:0] mask_rd;
  logic                      mask_bit;
  logic                      vis_we;
  logic [STATE_BITS-1:0]     vis_wa;
  logic                      vis_wd;
  logic                      vis_rd;
  perm_fn_t                  pu_fn;
  logic [STATE_BITS-1:0]     pu_a;
  logic [STATE_BITS-1:0]     pu_y;
  logic [STATE_BITS-1:0]     pu_z;

  // Ring size and scan limit
  assign len      = LEN_W'(rs_r) * LEN_W'(sb_r);
  assign size_bad = (rs_r == '0) || (sb_r == '0) || (len > LEN_W'(STATE_BITS));
  assign scan_lim = (STATE_BITS+1)'(1) << len;

  // Validity mask, one word per address
  rsce_ram #(.W(MASK_WORD_BITS), .D(MASK_DEPTH)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (MA_W'(in_ch.mask_address)),
    .wdata (MASK_WORD_BITS'(in_ch.mask_word)),
    .raddr (MA_W'(cand_r / MASK_WORD_BITS)),
    .rdata (mask_rd)
  );
  assign mask_bit = mask_rd[BI_W'(cand_r % MASK_WORD_BITS)];

  // Visited map, one bit per configuration
  rsce_ram #(.W(1), .D(CONF_COUNT)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_wa),
    .wdata (vis_wd),
    .raddr (cand_r),
    .rdata (vis_rd)
  );

  // Shared rotate / reflect-step unit
  assign pu_fn = (state_r == S_REF) ? PF_STEP : PF_ROT;
  assign pu_a  = (state_r == S_REF) ? sh_r : cand_r;

  rsce_perm_unit #(.STATE_BITS(STATE_BITS)) u_perm (
    .fn  (pu_fn),
    .a   (pu_a),
    .b   (acc_r),
    .len (len),
    .sb  (sb_r),
    .y   (pu_y),
    .z   (pu_z)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.representative = out_rep_r;
  assign out_ch.rotation_count = out_rc_r;
  assign out_ch.mirror_merged  = out_mm_r;
  assign out_ch.class_index    = out_ci_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    rs_nxt     = rs_r;
    sb_nxt     = sb_r;
    scan_nxt   = scan_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    n_nxt      = n_r;
    cand_nxt   = cand_r;
    ref_nxt    = ref_r;
    sh_nxt     = sh_r;
    acc_nxt    = acc_r;
    k_nxt      = k_r;
    rc_nxt     = rc_r;
    mm_nxt     = mm_r;
    fresh_nxt  = fresh_r;
    clr_nxt    = clr_r;
    res_st_nxt  = res_st_r;
    res_rep_nxt = res_rep_r;
    res_rc_nxt  = res_rc_r;
    res_mm_nxt  = res_mm_r;
    res_ci_nxt  = res_ci_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt  = out_st_r;
    out_rep_nxt = out_rep_r;
    out_rc_nxt  = out_rc_r;
    out_mm_nxt  = out_mm_r;
    out_ci_nxt  = out_ci_r;
    mask_we = 1'b0;
    vis_we  = 1'b0;
    vis_wa  = cand_r;
    vis_wd  = 1'b1;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_RING_SITES:  rs_nxt = cfg_wdata[SITES_W-1:0];
        CFG_SYMBOL_BITS: sb_nxt = cfg_wdata[SYMB_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        vis_we  = 1'b1;
        vis_wa  = clr_r;
        vis_wd  = 1'b0;
        clr_nxt = clr_r + STATE_BITS'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.operation)
            OP_LOAD: begin
              mask_we = (32'(in_ch.mask_address) < 32'(MASK_DEPTH));
            end
            OP_RESTART: begin
              scan_nxt   = '0;
              cnt_nxt    = '0;
              halted_nxt = 1'b0;
              clr_nxt    = '0;
              state_nxt  = S_CLEAR;
            end
            OP_PROCESS: begin
              if (size_bad) begin
                res_st_nxt  = ST_SIZE;
                res_rep_nxt = '0;
                res_rc_nxt  = '0;
                res_mm_nxt  = 1'b0;
                res_ci_nxt  = '0;
                state_nxt   = S_EMIT;
              end else if (!halted_r && (scan_r < scan_lim)) begin
                n_nxt     = scan_r[STATE_BITS-1:0];
                cand_nxt  = scan_r[STATE_BITS-1:0];
                scan_nxt  = scan_r + (STATE_BITS+1)'(1);
                rc_nxt    = '0;
                mm_nxt    = 1'b0;
                state_nxt = S_N_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_N_RD: state_nxt = S_N_CK;
      S_N_CK: begin
        if (mask_bit) begin
          state_nxt = S_IDLE;
        end else begin
          fresh_nxt = !vis_rd;
          if (!vis_rd && (pu_y != n_r)) begin
            cand_nxt  = pu_y;
            state_nxt = S_ROT_RD;
          end else begin
            sh_nxt    = n_r;
            acc_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_REF;
          end
        end
      end
      S_ROT_RD: state_nxt = S_ROT_CK;
      S_ROT_CK: begin
        if (mask_bit) begin
          res_st_nxt  = ST_ROT_BAD;
          res_rep_nxt = REP_W'(n_r);
          res_rc_nxt  = '0;
          res_mm_nxt  = 1'b0;
          res_ci_nxt  = CI_W'(cnt_r);
          halted_nxt  = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          rc_nxt = rc_r + RC_W'(1);
          vis_we = 1'b1;
          if (pu_y == n_r) begin
            sh_nxt    = n_r;
            acc_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_REF;
          end else begin
            cand_nxt  = pu_y;
            state_nxt = S_ROT_RD;
          end
        end
      end
      S_REF: begin
        // Move one symbol from the low end of n onto the mirror image
        sh_nxt  = pu_z;
        acc_nxt = pu_y;
        k_nxt   = k_r + SITES_W'(1);
        if (k_r == rs_r - SITES_W'(1)) begin
          cand_nxt  = pu_y;
          state_nxt = S_REFL_RD;
        end
      end
      S_REFL_RD: state_nxt = S_REFL_CK;
      S_REFL_CK: begin
        if (mask_bit) begin
          res_st_nxt  = ST_REF_BAD;
          res_rep_nxt = REP_W'(n_r);
          res_rc_nxt  = '0;
          res_mm_nxt  = 1'b0;
          res_ci_nxt  = CI_W'(cnt_r);
          halted_nxt  = 1'b1;
          state_nxt   = S_EMIT;
        end else if (!vis_rd && (cand_r > n_r)) begin
          vis_we  = 1'b1;
          mm_nxt  = 1'b1;
          ref_nxt = cand_r;
          if (pu_y == cand_r) begin
            state_nxt = S_FIN;
          end else begin
            cand_nxt  = pu_y;
            state_nxt = S_MROT_RD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MROT_RD: state_nxt = S_MROT_CK;
      S_MROT_CK: begin
        if (mask_bit) begin
          res_st_nxt  = ST_MROT_BAD;
          res_rep_nxt = REP_W'(n_r);
          res_rc_nxt  = '0;
          res_mm_nxt  = 1'b0;
          res_ci_nxt  = CI_W'(cnt_r);
          halted_nxt  = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          vis_we = 1'b1;
          if (pu_y == ref_r) begin
            state_nxt = S_FIN;
          end else begin
            cand_nxt  = pu_y;
            state_nxt = S_MROT_RD;
          end
        end
      end
      S_FIN: begin
        if (fresh_r) begin
          res_st_nxt  = ST_OK;
          res_rep_nxt = REP_W'(n_r);
          res_rc_nxt  = rc_r;
          res_mm_nxt  = mm_r;
          res_ci_nxt  = CI_W'(cnt_r);
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_rep_nxt   = res_rep_r;
          out_rc_nxt    = res_rc_r;
          out_mm_nxt    = res_mm_r;
          out_ci_nxt    = res_ci_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rs_r        <= SITES_W'(8);
      sb_r        <= SYMB_W'(1);
      scan_r      <= '0;
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rs_r        <= rs_nxt;
      sb_r        <= sb_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      halted_r    <= halted_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    cand_r    <= cand_nxt;
    ref_r     <= ref_nxt;
    sh_r      <= sh_nxt;
    acc_r     <= acc_nxt;
    k_r       <= k_nxt;
    rc_r      <= rc_nxt;
    mm_r      <= mm_nxt;
    fresh_r   <= fresh_nxt;
    res_st_r  <= res_st_nxt;
    res_rep_r <= res_rep_nxt;
    res_rc_r  <= res_rc_nxt;
    res_mm_r  <= res_mm_nxt;
    res_ci_r  <= res_ci_nxt;
    out_st_r  <= out_st_nxt;
    out_rep_r <= out_rep_nxt;
    out_rc_r  <= out_rc_nxt;
    out_mm_r  <= out_mm_nxt;
    out_ci_r  <= out_ci_nxt;
  end

  // Checks
  `RSCE_ASSERT_IMP(a_rot_walk_open, state_r == S_ROT_RD, cand_r != n_r,
    "rotation walk entered on its own start")
  `RSCE_ASSERT_IMP(a_halt_with_error, halted_r && !$past(halted_r), state_r == S_EMIT,
    "halt set without an error result")
  `RSCE_ASSERT_NXT(a_emit_from_seq, !out_valid_r && state_r != S_EMIT, !out_valid_r,
    "result appeared outside the emit step")

endmodule
`default_nettype wire
